// ----- rtl/arp_responder_cache_defines.svh -----
// Assertion macros for the ARP responder cache.
// Included by the top level; no other dependencies.
`ifndef ARP_RESPONDER_CACHE_DEFINES_SVH
`define ARP_RESPONDER_CACHE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ARC_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ARC_ASSERT_RESET(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("reset assertion failed");
`else
`define ARC_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ARC_ASSERT_RESET(lbl, clk, prop)
`endif
`endif

// ----- rtl/arc_pkg.sv -----
// Package for the ARP responder cache: constants, command and result codes,
// the state machine type and the cell control struct. No dependencies.
package arc_pkg;

    localparam int CACHE_ENTRIES_DEFAULT = 16;

    typedef enum logic [1:0] {
        CMD_PKT     = 2'd0,
        CMD_RESOLVE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_BAD     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_CONSUMED = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_REPLY    = 3'd2,
        KIND_REQUEST  = 3'd3,
        KIND_HIT      = 3'd4,
        KIND_VALID    = 3'd5,
        KIND_INVALID  = 3'd6
    } kind_t;

    localparam logic [2:0] REG_IF0_ENABLE = 3'd0;
    localparam logic [2:0] REG_IF0_IP     = 3'd1;
    localparam logic [2:0] REG_IF0_MAC    = 3'd2;
    localparam logic [2:0] REG_IF1_ENABLE = 3'd3;
    localparam logic [2:0] REG_IF1_IP     = 3'd4;
    localparam logic [2:0] REG_IF1_MAC    = 3'd5;

    localparam logic [10:0] MIN_PKT_LEN   = 11'd28;
    localparam logic [15:0] HW_TYPE_ETH   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [7:0]  HW_LEN_ETH    = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IP  = 8'd4;
    localparam logic [15:0] OPER_REQUEST  = 16'd1;
    localparam logic [1:0]  TX_OPER_REQ   = 2'd1;
    localparam logic [1:0]  TX_OPER_REPLY = 2'd2;
    localparam logic [7:0]  BCAST_BYTE    = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Control word broadcast to every cell of the chain alongside the data.
    typedef struct packed {
        logic        load;    // a slot takes ip and mac this cycle
        logic        shift;   // rotate contents one cell
    } cell_ctrl_t;

endpackage

// ----- rtl/arp_responder_cache.sv -----
// ARP responder cache: one transaction at a time. An accepted item rotates the
// cell chain once around (checking the head slot each cycle), then passes through
// a finishing state into the output state, where the result is presented; a new
// item is accepted only after the result is taken.
// Synchronous active-low reset clears the cache and the interface registers.
`include "arp_responder_cache_defines.svh"
module arp_responder_cache #(
    parameter int CACHE_ENTRIES = arc_pkg::CACHE_ENTRIES_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pkt_len, hw_type, proto_type, hw_len, proto_len, oper_code,
    // peer_mac, peer_ip, query_ip, entry_index, iface_sel (192 bits)
    input  logic [191:0] s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tx_iface, eth_dest, tx_oper, tx_src_mac, tx_src_ip, tx_dst_mac,
    // tx_dst_ip, mac_value, ip_value (291 bits, padded to 296)
    output logic [295:0] m_tdata,
    // out_kind
    output logic [2:0]   m_tuser
);

    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    // configuration
    logic        en_reg [2];
    logic [31:0] ifip_reg [2];
    logic [47:0] ifmac_reg [2];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                en_reg[k]    <= 1'b0;
                ifip_reg[k]  <= '0;
                ifmac_reg[k] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                arc_pkg::REG_IF0_ENABLE: en_reg[0]    <= cfg_data[0];
                arc_pkg::REG_IF0_IP:     ifip_reg[0]  <= cfg_data[31:0];
                arc_pkg::REG_IF0_MAC:    ifmac_reg[0] <= cfg_data;
                arc_pkg::REG_IF1_ENABLE: en_reg[1]    <= cfg_data[0];
                arc_pkg::REG_IF1_IP:     ifip_reg[1]  <= cfg_data[31:0];
                arc_pkg::REG_IF1_MAC:    ifmac_reg[1] <= cfg_data;
                default: ;
            endcase
        end
    end

    // held item
    logic [193:0] item_reg;
    logic [1:0]   cmd;
    logic [10:0]  pkt_len;
    logic [15:0]  hw_type, proto_type, oper_code;
    logic [7:0]   hw_len, proto_len;
    logic [47:0]  peer_mac;
    logic [31:0]  peer_ip, query_ip;
    logic [3:0]   entry_index;
    logic         iface_sel;

    assign cmd         = item_reg[1:0];
    assign pkt_len     = item_reg[12:2];
    assign hw_type     = item_reg[28:13];
    assign proto_type  = item_reg[44:29];
    assign hw_len      = item_reg[52:45];
    assign proto_len   = item_reg[60:53];
    assign oper_code   = item_reg[76:61];
    assign peer_mac    = item_reg[124:77];
    assign peer_ip     = item_reg[156:125];
    assign query_ip    = item_reg[188:157];
    assign entry_index = item_reg[192:189];
    assign iface_sel   = item_reg[193];

    arc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg;
    logic            found_reg, found_next;  // matching entry found
    logic [47:0]     fmac_reg, fmac_next;
    logic [31:0]     fip_reg, fip_next;
    logic            fvalid_reg, fvalid_next;
    logic            written_reg, written_next;

    logic            pkt_ok;
    assign pkt_ok = (pkt_len >= arc_pkg::MIN_PKT_LEN) && (hw_type == arc_pkg::HW_TYPE_ETH)
        && (proto_type == arc_pkg::PROTO_IPV4) && (hw_len == arc_pkg::HW_LEN_ETH)
        && (proto_len == arc_pkg::PROTO_LEN_IP);

    // chain: cell 0 is the head; contents rotate so cell i moves to cell i-1
    // and the head wraps to the tail. After CACHE_ENTRIES shifts all return.
    logic [31:0] c_ip    [CACHE_ENTRIES];
    logic [47:0] c_mac   [CACHE_ENTRIES];
    logic        c_valid [CACHE_ENTRIES];
    arc_pkg::cell_ctrl_t ctrl;
    logic        learn_hit, wrap_write;

    // head slot number during the scan is cnt_reg
    assign learn_hit = (state_reg == arc_pkg::ST_SCAN) && (cmd == arc_pkg::CMD_PKT) && pkt_ok
        && !written_reg && (!c_valid[0] || c_ip[0] == peer_ip);
    // no free slot: slot 0 is back at the head in the finishing cycle
    assign wrap_write = (state_reg == arc_pkg::ST_FINISH) && (cmd == arc_pkg::CMD_PKT)
        && pkt_ok && !written_reg;

    assign ctrl.shift = (state_reg == arc_pkg::ST_SCAN);
    assign ctrl.load  = learn_hit || wrap_write;

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        arc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .wr_en     (g == CACHE_ENTRIES - 1 ? learn_hit : (g == 0 ? wrap_write : 1'b0)),
            .wr_ip     (peer_ip),
            .wr_mac    (peer_mac),
            .prev_ip   (c_ip[(g + 1) % CACHE_ENTRIES]),
            .prev_mac  (c_mac[(g + 1) % CACHE_ENTRIES]),
            .prev_valid(c_valid[(g + 1) % CACHE_ENTRIES]),
            .ip_reg    (c_ip[g]),
            .mac_reg   (c_mac[g]),
            .valid_reg (c_valid[g])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            arc_pkg::ST_IDLE:   if (s_tvalid) state_next = arc_pkg::ST_SCAN;
            arc_pkg::ST_SCAN:
                if (cnt_reg == CW'(CACHE_ENTRIES - 1)) state_next = arc_pkg::ST_FINISH;
            arc_pkg::ST_FINISH: state_next = arc_pkg::ST_OUT;
            arc_pkg::ST_OUT:    if (m_tready) state_next = arc_pkg::ST_IDLE;
            default:            state_next = arc_pkg::ST_IDLE;
        endcase
    end

    // scan bookkeeping
    always_comb begin
        found_next   = found_reg;
        fmac_next    = fmac_reg;
        fip_next     = fip_reg;
        fvalid_next  = fvalid_reg;
        written_next = written_reg || learn_hit || wrap_write;
        if (state_reg == arc_pkg::ST_SCAN) begin
            if (cmd == arc_pkg::CMD_RESOLVE && !found_reg && c_valid[0]
                    && c_ip[0] == query_ip) begin
                found_next = 1'b1;
                fmac_next  = c_mac[0];
            end
            if (cmd == arc_pkg::CMD_READ && {{(32 - CW){1'b0}}, cnt_reg}
                    == {28'd0, entry_index}) begin
                found_next  = 1'b1;
                fvalid_next = c_valid[0];
                fmac_next   = c_mac[0];
                fip_next    = c_ip[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= arc_pkg::ST_IDLE;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            fvalid_reg  <= 1'b0;
            written_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            found_reg   <= found_next;
            fvalid_reg  <= fvalid_next;
            written_reg <= written_next;
            if (state_reg == arc_pkg::ST_SCAN) cnt_reg <= cnt_reg + CW'(1);
            if (state_reg == arc_pkg::ST_IDLE) begin
                cnt_reg     <= '0;
                found_reg   <= 1'b0;
                fvalid_reg  <= 1'b0;
                written_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fmac_reg <= fmac_next;
        fip_reg  <= fip_next;
        if (state_reg == arc_pkg::ST_IDLE && s_tvalid) item_reg <= {s_tdata, s_tuser};
    end

    // outputs
    logic [2:0]  kind;
    logic        tx_iface;
    logic [47:0] eth_dest, tx_src_mac, tx_dst_mac, mac_value;
    logic [1:0]  tx_oper;
    logic [31:0] tx_src_ip, tx_dst_ip, ip_value;
    logic        m0, m1;

    assign m0 = en_reg[0] && ifip_reg[0] == query_ip;
    assign m1 = en_reg[1] && ifip_reg[1] == query_ip;

    always_comb begin
        kind = arc_pkg::KIND_REJECTED;
        tx_iface = 1'b0; eth_dest = '0; tx_oper = '0; tx_src_mac = '0;
        tx_src_ip = '0; tx_dst_mac = '0; tx_dst_ip = '0; mac_value = '0; ip_value = '0;
        case (cmd)
            arc_pkg::CMD_PKT: begin
                if (pkt_ok) begin
                    kind = arc_pkg::KIND_CONSUMED;
                    if (oper_code == arc_pkg::OPER_REQUEST && (m0 || m1)) begin
                        kind       = arc_pkg::KIND_REPLY;
                        tx_iface   = !m0;
                        eth_dest   = peer_mac;
                        tx_oper    = arc_pkg::TX_OPER_REPLY;
                        tx_src_mac = m0 ? ifmac_reg[0] : ifmac_reg[1];
                        tx_src_ip  = query_ip;
                        tx_dst_mac = peer_mac;
                        tx_dst_ip  = peer_ip;
                    end
                end
            end
            arc_pkg::CMD_RESOLVE: begin
                if (found_reg) begin
                    kind      = arc_pkg::KIND_HIT;
                    mac_value = fmac_reg;
                end else begin
                    kind       = arc_pkg::KIND_REQUEST;
                    tx_iface   = iface_sel;
                    eth_dest   = {6{arc_pkg::BCAST_BYTE}};
                    tx_oper    = arc_pkg::TX_OPER_REQ;
                    tx_src_mac = ifmac_reg[iface_sel];
                    tx_src_ip  = ifip_reg[iface_sel];
                    tx_dst_ip  = query_ip;
                end
            end
            arc_pkg::CMD_READ: begin
                if (found_reg && fvalid_reg) begin
                    kind      = arc_pkg::KIND_VALID;
                    mac_value = fmac_reg;
                    ip_value  = fip_reg;
                end else begin
                    kind = arc_pkg::KIND_INVALID;
                end
            end
            default: kind = arc_pkg::KIND_REJECTED;
        endcase
    end

    assign s_tready = (state_reg == arc_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == arc_pkg::ST_OUT);
    assign m_tuser  = kind;
    assign m_tdata  = {5'd0, ip_value, mac_value, tx_dst_ip, tx_dst_mac, tx_src_ip,
                       tx_src_mac, tx_oper, eth_dest, tx_iface};

    `ARC_ASSERT_IMPL(a_one_side, aclk, aresetn, !(s_tready && m_tvalid))
    `ARC_ASSERT_IMPL(a_scan_len, aclk, aresetn,
        (state_reg == arc_pkg::ST_FINISH) |-> (cnt_reg == CW'(CACHE_ENTRIES)))
    `ARC_ASSERT_IMPL(a_learn_once, aclk, aresetn, !(written_reg && ctrl.load))
    `ARC_ASSERT_RESET(a_reset_idle, aclk, !aresetn |=> s_tready && !m_tvalid)

endmodule

// ----- rtl/arc_cell.sv -----
// One cache slot of the rotating chain: ip, mac and valid flag.
// Depends on arc_pkg.
module arc_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  arc_pkg::cell_ctrl_t ctrl,
    input  logic               wr_en,
    input  logic [31:0]        wr_ip,
    input  logic [47:0]        wr_mac,
    input  logic [31:0]        prev_ip,
    input  logic [47:0]        prev_mac,
    input  logic               prev_valid,
    output logic [31:0]        ip_reg,
    output logic [47:0]        mac_reg,
    output logic               valid_reg
);

    logic [31:0] ip_next;
    logic [47:0] mac_next;
    logic        valid_next;

    always_comb begin
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            ip_next    = prev_ip;
            mac_next   = prev_mac;
            valid_next = prev_valid;
        end
        if (ctrl.load && wr_en) begin
            ip_next    = wr_ip;
            mac_next   = wr_mac;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg    <= '0;
            mac_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            ip_reg    <= ip_next;
            mac_reg   <= mac_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- verif/tb_arp_responder_cache.sv -----
// Self-checking testbench for the ARP responder cache: directed and random
// commands, a transaction-level predictor and an in-order scoreboard.
// Depends on arc_pkg and the arp_responder_cache top level.
module tb_arp_responder_cache;

    localparam int N_SLOTS = arc_pkg::CACHE_ENTRIES_DEFAULT;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] ip_value;
        logic [47:0] mac_value;
        logic [31:0] tx_dst_ip;
        logic [47:0] tx_dst_mac;
        logic [31:0] tx_src_ip;
        logic [47:0] tx_src_mac;
        logic [1:0]  tx_oper;
        logic [47:0] eth_dest;
        logic        tx_iface;
    } arp_result_t;

    typedef struct packed {
        logic        iface_sel;
        logic [3:0]  entry_index;
        logic [31:0] query_ip;
        logic [31:0] peer_ip;
        logic [47:0] peer_mac;
        logic [15:0] oper_code;
        logic [7:0]  proto_len;
        logic [7:0]  hw_len;
        logic [15:0] proto_type;
        logic [15:0] hw_type;
        logic [10:0] pkt_len;
        logic [1:0]  cmd;
    } arp_cmd_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [47:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [295:0] m_tdata;
    logic [2:0]   m_tuser;

    arp_responder_cache dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Predictor state: cache contents and interface registers.
    logic [31:0] cache_ip [N_SLOTS];
    logic [47:0] cache_mac [N_SLOTS];
    logic        cache_valid [N_SLOTS];
    logic        ifc_en [2];
    logic [31:0] ifc_ip [2];
    logic [47:0] ifc_mac [2];

    arp_cmd_t    cmd_queue [$];
    arp_result_t expected_results [$];
    arp_cmd_t    cur_cmd;
    int          errors = 0;
    bit          stim_done = 0;
    bit          stall_start = 0;
    logic        hold_off = 1'b0;

    // Small address pools reused so that resolve hits happen often.
    logic [31:0] ip_pool [8];
    logic [47:0] mac_pool [8];

    function automatic arp_result_t predict_arp(arp_cmd_t c);
        arp_result_t r;
        int slot;
        bit found;
        r = '0;
        case (arc_pkg::cmd_t'(c.cmd))
            arc_pkg::CMD_PKT: begin
                if (c.pkt_len < arc_pkg::MIN_PKT_LEN || c.hw_type != arc_pkg::HW_TYPE_ETH ||
                        c.proto_type != arc_pkg::PROTO_IPV4 ||
                        c.hw_len != arc_pkg::HW_LEN_ETH ||
                        c.proto_len != arc_pkg::PROTO_LEN_IP) begin
                    r.kind = arc_pkg::KIND_REJECTED;
                end else begin
                    slot = -1;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (slot < 0 && (!cache_valid[i] || cache_ip[i] == c.peer_ip))
                            slot = i;
                    if (slot < 0) slot = 0;
                    cache_ip[slot] = c.peer_ip;
                    cache_mac[slot] = c.peer_mac;
                    cache_valid[slot] = 1'b1;
                    r.kind = arc_pkg::KIND_CONSUMED;
                    found = 0;
                    if (c.oper_code == arc_pkg::OPER_REQUEST) begin
                        for (int i = 0; i < 2; i++) begin
                            if (!found && ifc_en[i] && ifc_ip[i] == c.query_ip) begin
                                found = 1;
                                r.kind = arc_pkg::KIND_REPLY;
                                r.tx_iface = i[0];
                                r.eth_dest = c.peer_mac;
                                r.tx_oper = arc_pkg::TX_OPER_REPLY;
                                r.tx_src_mac = ifc_mac[i];
                                r.tx_src_ip = c.query_ip;
                                r.tx_dst_mac = c.peer_mac;
                                r.tx_dst_ip = c.peer_ip;
                            end
                        end
                    end
                end
            end
            arc_pkg::CMD_RESOLVE: begin
                found = 0;
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (!found && cache_valid[i] && cache_ip[i] == c.query_ip) begin
                        found = 1;
                        r.kind = arc_pkg::KIND_HIT;
                        r.mac_value = cache_mac[i];
                    end
                end
                if (!found) begin
                    r.kind = arc_pkg::KIND_REQUEST;
                    r.tx_iface = c.iface_sel;
                    r.eth_dest = '1;
                    r.tx_oper = arc_pkg::TX_OPER_REQ;
                    r.tx_src_mac = ifc_mac[c.iface_sel];
                    r.tx_src_ip = ifc_ip[c.iface_sel];
                    r.tx_dst_ip = c.query_ip;
                end
            end
            arc_pkg::CMD_READ: begin
                if (cache_valid[c.entry_index]) begin
                    r.kind = arc_pkg::KIND_VALID;
                    r.mac_value = cache_mac[c.entry_index];
                    r.ip_value = cache_ip[c.entry_index];
                end else begin
                    r.kind = arc_pkg::KIND_INVALID;
                end
            end
            default: r.kind = arc_pkg::KIND_REJECTED;
        endcase
        return r;
    endfunction

    function automatic arp_cmd_t random_cmd();
        logic [255:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return rnd[193:0];
    endfunction

    function automatic arp_cmd_t make_packet(bit good, logic [15:0] oper,
                                             logic [47:0] mac, logic [31:0] sip,
                                             logic [31:0] tip);
        arp_cmd_t c;
        c = random_cmd();
        c.cmd = arc_pkg::CMD_PKT;
        c.oper_code = oper;
        c.peer_mac = mac;
        c.peer_ip = sip;
        c.query_ip = tip;
        if (good) begin
            c.pkt_len = 11'($urandom_range(2047, 28));
            c.hw_type = arc_pkg::HW_TYPE_ETH;
            c.proto_type = arc_pkg::PROTO_IPV4;
            c.hw_len = arc_pkg::HW_LEN_ETH;
            c.proto_len = arc_pkg::PROTO_LEN_IP;
        end
        return c;
    endfunction

    function automatic arp_cmd_t make_other(arc_pkg::cmd_t kind, logic [31:0] tip);
        arp_cmd_t c;
        c = random_cmd();
        c.cmd = kind;
        c.query_ip = tip;
        return c;
    endfunction

    // Driver: one command per transaction with a random gap after each.
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_results.push_back(predict_arp(cur_cmd));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                cur_cmd = cmd_queue.pop_front();
                s_tuser <= cur_cmd.cmd;
                s_tdata <= cur_cmd[193:2];
                s_tvalid <= 1'b1;
                src_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall control.
    int sink_gap = 0;
    always @(posedge aclk) begin
        arp_result_t got, want;
        int gap;
        if (aresetn && m_tvalid && m_tready) begin
            got = arp_result_t'({m_tuser, m_tdata[290:0]});
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d", $time, m_tuser);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[295:291] !== 5'b0) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (m_tready && m_tvalid) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
            sink_gap <= gap;
            m_tready <= (gap == 0);
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Receiver pressure: m_tready stays low for a long stretch once.
    initial begin
        wait (stall_start);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            arc_pkg::REG_IF0_ENABLE: ifc_en[0] = val[0];
            arc_pkg::REG_IF0_IP:     ifc_ip[0] = val[31:0];
            arc_pkg::REG_IF0_MAC:    ifc_mac[0] = val;
            arc_pkg::REG_IF1_ENABLE: ifc_en[1] = val[0];
            arc_pkg::REG_IF1_IP:     ifc_ip[1] = val[31:0];
            arc_pkg::REG_IF1_MAC:    ifc_mac[1] = val;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (cmd_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_interfaces(logic e0, logic [31:0] ip0, logic [47:0] m0,
                                  logic e1, logic [31:0] ip1, logic [47:0] m1);
        write_reg(arc_pkg::REG_IF0_ENABLE, {47'b0, e0});
        write_reg(arc_pkg::REG_IF0_IP, {16'b0, ip0});
        write_reg(arc_pkg::REG_IF0_MAC, m0);
        write_reg(arc_pkg::REG_IF1_ENABLE, {47'b0, e1});
        write_reg(arc_pkg::REG_IF1_IP, {16'b0, ip1});
        write_reg(arc_pkg::REG_IF1_MAC, m1);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic drawing addresses from a small pool.
    task automatic queue_random(int count);
        int pick;
        logic [31:0] tip;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            tip = ($urandom_range(3) == 0) ? $urandom : ip_pool[$urandom_range(7)];
            if ($urandom_range(4) == 0) tip = ifc_ip[$urandom_range(1)];
            if (pick < 45)
                cmd_queue.push_back(make_packet(1, ($urandom_range(2) == 0) ? 16'($urandom) :
                    16'(arc_pkg::OPER_REQUEST + $urandom_range(1)),
                    ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                        mac_pool[$urandom_range(7)],
                    ($urandom_range(3) == 0) ? $urandom : ip_pool[$urandom_range(7)], tip));
            else if (pick < 55)
                cmd_queue.push_back(make_packet($urandom_range(1) == 0, 16'($urandom),
                    48'({$urandom, $urandom}), $urandom, tip));
            else if (pick < 75)
                cmd_queue.push_back(make_other(arc_pkg::CMD_RESOLVE, tip));
            else if (pick < 95)
                cmd_queue.push_back(make_other(arc_pkg::CMD_READ, tip));
            else
                cmd_queue.push_back(make_other(arc_pkg::CMD_BAD, tip));
        end
    endtask

    initial begin
        arp_cmd_t c;
        for (int i = 0; i < N_SLOTS; i++) begin
            cache_ip[i] = '0;
            cache_mac[i] = '0;
            cache_valid[i] = 1'b0;
        end
        for (int i = 0; i < 2; i++) begin
            ifc_en[i] = 0;
            ifc_ip[i] = '0;
            ifc_mac[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            ip_pool[i] = $urandom;
            mac_pool[i] = 48'({$urandom, $urandom});
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, every command, every rejection reason.
        set_interfaces(1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 32'h0000_0000, 48'h0);
        cmd_queue.push_back(make_other(arc_pkg::CMD_READ, 0));
        cmd_queue.push_back(make_other(arc_pkg::CMD_RESOLVE, 32'h0));
        c = make_packet(1, arc_pkg::OPER_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        c.pkt_len = 11'd28;
        cmd_queue.push_back(c);
        c = make_packet(1, arc_pkg::OPER_REQUEST, 48'h0, 32'hFFFF_FFFF, 32'h0);
        c.pkt_len = 11'd2047;
        cmd_queue.push_back(c);
        c = make_packet(1, 16'd2, 48'h1, 32'h1, 32'hFFFF_FFFF);
        cmd_queue.push_back(c);
        c = make_packet(1, arc_pkg::OPER_REQUEST, 48'h2, 32'h2, 32'h1);
        c.pkt_len = 11'd27;
        cmd_queue.push_back(c);
        c = make_packet(1, arc_pkg::OPER_REQUEST, 48'h2, 32'h2, 32'h1);
        c.hw_type = 16'hFFFF;
        cmd_queue.push_back(c);
        c = make_packet(1, arc_pkg::OPER_REQUEST, 48'h2, 32'h2, 32'h1);
        c.proto_type = arc_pkg::ETHERTYPE_ARP;
        cmd_queue.push_back(c);
        c = make_packet(1, arc_pkg::OPER_REQUEST, 48'h2, 32'h2, 32'h1);
        c.hw_len = 8'hFF;
        cmd_queue.push_back(c);
        c = make_packet(1, arc_pkg::OPER_REQUEST, 48'h2, 32'h2, 32'h1);
        c.proto_len = 8'h0;
        cmd_queue.push_back(c);
        // Fill the cache past capacity so slot 0 gets overwritten.
        for (int i = 0; i < 17; i++)
            cmd_queue.push_back(make_packet(1, 16'hFFFF, 48'({$urandom, $urandom}),
                32'h1000 + i, 32'h5));
        cmd_queue.push_back(make_other(arc_pkg::CMD_RESOLVE, 32'h1000 + 16));
        cmd_queue.push_back(make_other(arc_pkg::CMD_READ, 0));
        c = make_other(arc_pkg::CMD_READ, 0);
        c.entry_index = 4'd15;
        cmd_queue.push_back(c);
        c = make_other(arc_pkg::CMD_RESOLVE, 32'hDEAD_BEEF);
        c.iface_sel = 1'b1;
        cmd_queue.push_back(c);
        cmd_queue.push_back(make_other(arc_pkg::CMD_BAD, 32'h0));
        drain_results();

        // Random phases across several interface settings, with one long stall.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_interfaces(0, 32'h0, 48'h0, 0, 32'h0, 48'h0);
                1: set_interfaces(1, ip_pool[0], 48'({$urandom, $urandom}),
                                  1, ip_pool[1], 48'({$urandom, $urandom}));
                2: set_interfaces(0, ip_pool[2], 48'({$urandom, $urandom}),
                                  1, ip_pool[2], 48'hFFFF_FFFF_FFFF);
                default: set_interfaces(1, ip_pool[3], 48'({$urandom, $urandom}),
                                        0, ip_pool[4], 48'h0);
            endcase
            if (phase == 1) stall_start = 1;
            queue_random(175);
            drain_results();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0)
            $display("tb_arp_responder_cache: PASS");
        else
            $display("tb_arp_responder_cache: FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_arp_responder_cache: FAIL");
        $finish;
    end

endmodule

// ----- arp_responder_cache.f -----
+incdir+rtl
rtl/arc_pkg.sv
rtl/arc_cell.sv
rtl/arp_responder_cache.sv
verif/tb_arp_responder_cache.sv
